/* rtl/vtat_pkg.sv */
package vtat_pkg;

  localparam int MAX_DEG     = 64;
  localparam int ARC_W       = 6;
  localparam int DEG_W       = 7;
  localparam int DIST_W      = 7;
  localparam int STACK_DEPTH = MAX_DEG / 2;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // func codes
  localparam logic [2:0] FN_INIT  = 3'd0;
  localparam logic [2:0] FN_LEAVE = 3'd1;
  localparam logic [2:0] FN_ENTER = 3'd2;
  localparam logic [2:0] FN_MARRY = 3'd3;
  localparam logic [2:0] FN_MATCH = 3'd4;
  localparam logic [2:0] FN_START = 3'd5;

  typedef struct packed {
    logic [2:0]       func;
    logic [ARC_W-1:0] arc_a;
    logic [ARC_W-1:0] arc_b;
  } in_word_t;

  typedef struct packed {
    logic [ARC_W-1:0] result_arc;
    logic             result_none;
    logic             is_black;
    logic             is_grey;
    logic             is_even;
    logic             has_start;
    logic [ARC_W-1:0] last_closed;
    logic             last_closed_none;
  } out_word_t;

endpackage

/* rtl/vtat_ram.sv */
module vtat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vertex_trail_arc_tracker_core.sv */
// Init, marry with a bad arc and unused codes go straight to the result strobe;
// leave unlinks one list entry, enter up to two, through the bit-serial modulo unit.
// Match query runs a bracket scan, one entry a cycle; the starting-arc query
// repeats that lookup per arc. One word in flight; busy is high meanwhile.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (rst_n low, synchronous) equals init with degree 0.
module vertex_trail_arc_tracker_core
  import vtat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [DEG_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD, ST_LV_C, ST_UL_RD, ST_UL_LAT, ST_UL_P, ST_UL_PW, ST_UL_N,
    ST_UL_NW, ST_UL_END, ST_CUR_LAT, ST_CUR_FIX, ST_PO_START, ST_PO_FIND0,
    ST_PO_FIND, ST_PO_SCAN, ST_PO_RET, ST_FIN
  } state_t;

  localparam int AW = $clog2(MAX_DEG);

  state_t state_r, ret_r;
  logic [DEG_W-1:0] degree_r;
  logic [2:0] func_r;
  logic [ARC_W-1:0] a_r, b_r, pos_r, p_r, n_r, j_r, po_idx_r, po_res_r, am_r;
  logic [ARC_W-1:0] res_r, closed_r, cursor_r;
  logic none_r, closed_v_r, ph_r, ok_r;
  logic black_r, grey_r, even_r, hstart_r;
  logic [DIST_W-1:0] pl_r, nl_r;
  logic [7:0] mod_x_r;
  logic [2:0] mod_i_r;
  logic [DEG_W-1:0] k_r, i_r;
  logic [MAX_DEG-1:0] matched_r, entered_r, prev_vld_r, next_vld_r;
  logic pv_q_r, nv_q_r;
  logic [ARC_W-1:0] stack_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r;
  logic [ARC_W-1:0] pair_a_r [2];
  logic [ARC_W-1:0] pair_b_r [2];
  logic [1:0] pair_v_r;
  logic out_valid_r;
  out_word_t out_word_r;

  logic [DEG_W-1:0] d;
  logic [DIST_W-1:0] prev_rdata, next_rdata, prev_eff, next_eff;
  logic [AW-1:0] prev_raddr, next_raddr;
  logic prev_we, next_we;
  logic [DIST_W-1:0] prev_wdata, next_wdata;
  logic [ARC_W-1:0] p_calc, n_calc, cur_calc, j_inc, pop_val;
  logic [14:0] mod_sh;
  logic [MAX_DEG-1:0] flip_mask;

  // p + d - m, reduced once; m < d
  function automatic logic [ARC_W-1:0] back_wrap(input logic [ARC_W-1:0] pos,
      input logic [DIST_W-1:0] m, input logic [DEG_W-1:0] dd);
    logic [7:0] t;
    t = 8'(pos) + 8'(dd) - 8'(m);
    if (t >= 8'(dd)) t = t - 8'(dd);
    return t[ARC_W-1:0];
  endfunction

  function automatic logic [ARC_W-1:0] fwd_wrap(input logic [ARC_W-1:0] pos,
      input logic [DIST_W-1:0] m, input logic [DEG_W-1:0] dd);
    logic [7:0] t;
    t = 8'(pos) + 8'(m);
    if (t >= 8'(dd)) t = t - 8'(dd);
    return t[ARC_W-1:0];
  endfunction

  function automatic logic [MAX_DEG-1:0] oh_lt(input logic [ARC_W-1:0] x,
      input logic [DEG_W-1:0] dd);
    logic [MAX_DEG-1:0] v;
    v = '0;
    if (7'(x) < dd) v[x] = 1'b1;
    return v;
  endfunction

  assign d = (degree_r > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : degree_r;
  assign prev_eff = pv_q_r ? prev_rdata : DIST_W'(1);
  assign next_eff = nv_q_r ? next_rdata : DIST_W'(1);
  assign p_calc   = back_wrap(pos_r, mod_x_r[DIST_W-1:0], d);
  assign n_calc   = fwd_wrap(pos_r, mod_x_r[DIST_W-1:0], d);
  assign cur_calc = back_wrap(n_r, mod_x_r[DIST_W-1:0], d);
  assign j_inc    = (7'(j_r) + 7'd1 == d) ? '0 : j_r + 1'b1;
  assign pop_val  = stack_r[5'(sp_r - 1'b1)];
  assign mod_sh   = 15'(d) << mod_i_r;
  assign flip_mask = oh_lt(am_r, d) ^ oh_lt(a_r, d) ^ oh_lt(po_res_r, d) ^ oh_lt(b_r, d);

  // distance memory port control
  always_comb begin
    prev_raddr = pos_r;
    next_raddr = pos_r;
    unique case (state_r)
      ST_UL_P:   next_raddr = p_calc;
      ST_UL_N:   prev_raddr = n_calc;
      ST_UL_END: prev_raddr = n_r;
      default: ;
    endcase
    prev_we    = (state_r == ST_UL_NW);
    next_we    = (state_r == ST_UL_PW);
    prev_wdata = prev_eff + pl_r;
    next_wdata = next_eff + nl_r;
  end

  vtat_ram #(.WIDTH(DIST_W), .DEPTH(MAX_DEG)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(n_r), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_rdata)
  );

  vtat_ram #(.WIDTH(DIST_W), .DEPTH(MAX_DEG)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(p_r), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      degree_r    <= '0;
      matched_r   <= '0;
      entered_r   <= '0;
      prev_vld_r  <= '0;
      next_vld_r  <= '0;
      pair_v_r    <= '0;
      closed_v_r  <= 1'b0;
      closed_r    <= '0;
      cursor_r    <= '0;
      grey_r      <= 1'b0;
      hstart_r    <= 1'b0;
      even_r      <= 1'b1;
      black_r     <= 1'b1;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
    end else begin
      if (cfg_we) degree_r <= cfg_wdata;
      pv_q_r      <= prev_vld_r[prev_raddr];
      nv_q_r      <= next_vld_r[next_raddr];
      if (prev_we) prev_vld_r[n_r] <= 1'b1;
      if (next_we) next_vld_r[p_r] <= 1'b1;
      out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            func_r <= in_word.func;
            a_r    <= in_word.arc_a;
            b_r    <= in_word.arc_b;
            res_r  <= '0;
            none_r <= 1'b1;
            ph_r   <= 1'b0;
            state_r <= ST_FIN;
            case (in_word.func)
              FN_INIT: begin
                matched_r  <= '0;
                entered_r  <= '0;
                prev_vld_r <= '0;
                next_vld_r <= '0;
                pair_v_r   <= '0;
                closed_v_r <= 1'b0;
                closed_r   <= '0;
                cursor_r   <= '0;
                grey_r     <= 1'b0;
                hstart_r   <= 1'b0;
                even_r     <= ~d[0];
                black_r    <= (d == '0);
              end
              FN_LEAVE: begin
                if (!black_r && d != '0) begin
                  grey_r   <= 1'b1;
                  hstart_r <= 1'b1;
                  mod_x_r  <= 8'(cursor_r);
                  mod_i_r  <= 3'd7;
                  ret_r    <= ST_LV_C;
                  state_r  <= ST_MOD;
                end
              end
              FN_ENTER: begin
                if (!black_r && d != '0 && 7'(in_word.arc_a) < d) begin
                  grey_r <= 1'b1;
                  entered_r[in_word.arc_a] <= 1'b1;
                  pos_r   <= in_word.arc_a;
                  state_r <= ST_UL_RD;
                end
              end
              FN_MARRY: begin
                if (7'(in_word.arc_a) < d && 7'(in_word.arc_b) < d) begin
                  po_idx_r <= in_word.arc_a;
                  state_r  <= ST_PO_START;
                end
              end
              FN_MATCH: begin
                po_idx_r <= in_word.arc_a;
                state_r  <= ST_PO_START;
              end
              FN_START: begin
                if (hstart_r && d != '0) begin
                  i_r      <= '0;
                  po_idx_r <= '0;
                  state_r  <= ST_PO_START;
                end
              end
              default: ;
            endcase
          end
        end

        // restoring remainder, one bit a cycle
        ST_MOD: begin
          if (15'(mod_x_r) >= mod_sh) mod_x_r <= mod_x_r - mod_sh[7:0];
          if (mod_i_r == '0) state_r <= ret_r;
          mod_i_r <= mod_i_r - 1'b1;
        end

        ST_LV_C: begin
          res_r   <= mod_x_r[ARC_W-1:0];
          none_r  <= 1'b0;
          pos_r   <= mod_x_r[ARC_W-1:0];
          state_r <= ST_UL_RD;
        end

        // unlink pos_r from the circular list
        ST_UL_RD: state_r <= ST_UL_LAT;
        ST_UL_LAT: begin
          pl_r    <= prev_eff;
          nl_r    <= next_eff;
          mod_x_r <= 8'(prev_eff);
          mod_i_r <= 3'd7;
          ret_r   <= ST_UL_P;
          state_r <= ST_MOD;
        end
        ST_UL_P: begin
          if (p_calc == pos_r) begin
            ok_r    <= 1'b0;
            state_r <= ST_UL_END;
          end else begin
            p_r     <= p_calc;
            state_r <= ST_UL_PW;
          end
        end
        ST_UL_PW: begin
          mod_x_r <= 8'(nl_r);
          mod_i_r <= 3'd7;
          ret_r   <= ST_UL_N;
          state_r <= ST_MOD;
        end
        ST_UL_N: begin
          n_r     <= n_calc;
          state_r <= ST_UL_NW;
        end
        ST_UL_NW: begin
          ok_r    <= 1'b1;
          state_r <= ST_UL_END;
        end
        ST_UL_END: begin
          state_r <= ST_FIN;
          if (!ok_r) begin
            black_r  <= 1'b1;
            cursor_r <= '0;
          end else if (func_r == FN_LEAVE) begin
            cursor_r <= n_r;
            even_r   <= ~even_r;
          end else if (!ph_r) begin
            matched_r[a_r] <= 1'b1;
            matched_r[n_r] <= 1'b1;
            closed_r   <= n_r;
            closed_v_r <= 1'b1;
            res_r      <= n_r;
            none_r     <= 1'b0;
            pos_r      <= n_r;
            ph_r       <= 1'b1;
            state_r    <= ST_UL_RD;
          end else begin
            state_r <= ST_CUR_LAT;
          end
        end
        ST_CUR_LAT: begin
          mod_x_r <= 8'(prev_eff);
          mod_i_r <= 3'd7;
          ret_r   <= ST_CUR_FIX;
          state_r <= ST_MOD;
        end
        ST_CUR_FIX: begin
          cursor_r <= cur_calc;
          state_r  <= ST_FIN;
        end

        // partner lookup for po_idx_r
        ST_PO_START: begin
          state_r <= ST_PO_RET;
          if (pair_v_r[0] && pair_a_r[0] == po_idx_r) po_res_r <= pair_b_r[0];
          else if (pair_v_r[0] && pair_b_r[0] == po_idx_r) po_res_r <= pair_a_r[0];
          else if (pair_v_r[1] && pair_a_r[1] == po_idx_r) po_res_r <= pair_b_r[1];
          else if (pair_v_r[1] && pair_b_r[1] == po_idx_r) po_res_r <= pair_a_r[1];
          else if (7'(po_idx_r) >= d || !matched_r[po_idx_r]) po_res_r <= po_idx_r;
          else if (closed_v_r) begin
            mod_x_r <= 8'(closed_r) + 8'd1;
            mod_i_r <= 3'd7;
            ret_r   <= ST_PO_FIND0;
            state_r <= ST_MOD;
          end else begin
            j_r     <= '0;
            k_r     <= '0;
            state_r <= ST_PO_FIND;
          end
        end
        ST_PO_FIND0: begin
          j_r     <= mod_x_r[ARC_W-1:0];
          k_r     <= '0;
          state_r <= ST_PO_FIND;
        end
        ST_PO_FIND: begin
          if (k_r < d && !matched_r[j_r]) begin
            j_r <= j_inc;
            k_r <= k_r + 1'b1;
          end else begin
            k_r     <= '0;
            sp_r    <= '0;
            state_r <= ST_PO_SCAN;
          end
        end
        ST_PO_SCAN: begin
          if (k_r < d) begin
            j_r <= j_inc;
            k_r <= k_r + 1'b1;
            if (matched_r[j_r]) begin
              if (entered_r[j_r]) begin
                if (sp_r < SP_W'(STACK_DEPTH)) begin
                  stack_r[sp_r[SP_W-2:0]] <= j_r;
                  sp_r <= sp_r + 1'b1;
                end
              end else if (sp_r != '0) begin
                sp_r <= sp_r - 1'b1;
                if (po_idx_r == pop_val) begin
                  po_res_r <= j_r;
                  state_r  <= ST_PO_RET;
                end else if (po_idx_r == j_r) begin
                  po_res_r <= pop_val;
                  state_r  <= ST_PO_RET;
                end
              end
            end
          end else begin
            po_res_r <= po_idx_r;
            state_r  <= ST_PO_RET;
          end
        end
        ST_PO_RET: begin
          state_r <= ST_FIN;
          case (func_r)
            FN_MATCH: begin
              res_r  <= po_res_r;
              none_r <= 1'b0;
            end
            FN_MARRY: begin
              if (!ph_r) begin
                am_r     <= po_res_r;
                po_idx_r <= b_r;
                ph_r     <= 1'b1;
                state_r  <= ST_PO_START;
              end else begin
                matched_r <= matched_r ^ flip_mask;
                if (pair_v_r[0]) begin
                  pair_a_r[1] <= a_r;
                  pair_b_r[1] <= b_r;
                  pair_v_r[1] <= 1'b1;
                end else begin
                  pair_a_r[0] <= a_r;
                  pair_b_r[0] <= b_r;
                  pair_v_r[0] <= 1'b1;
                end
              end
            end
            default: begin
              if (po_res_r == i_r[ARC_W-1:0] && !entered_r[i_r[ARC_W-1:0]]) begin
                res_r  <= i_r[ARC_W-1:0];
                none_r <= 1'b0;
              end else if (i_r + 1'b1 < d) begin
                i_r      <= i_r + 1'b1;
                po_idx_r <= ARC_W'(i_r + 1'b1);
                state_r  <= ST_PO_START;
              end
            end
          endcase
        end

        ST_FIN: begin
          out_valid_r <= 1'b1;
          out_word_r.result_arc       <= none_r ? '0 : res_r;
          out_word_r.result_none      <= none_r;
          out_word_r.is_black         <= black_r;
          out_word_r.is_grey          <= grey_r;
          out_word_r.is_even          <= even_r;
          out_word_r.has_start        <= hstart_r;
          out_word_r.last_closed      <= closed_v_r ? closed_r : '0;
          out_word_r.last_closed_none <= ~closed_v_r;
          state_r <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/vtat_checker.sv */
module vtat_checker
  import vtat_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // an accepted word always makes the block busy in the cycle after it
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");

  // one strobe per word, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe repeated");

  // result is delivered when the block has gone idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.result_none |-> out_word.result_arc == '0)
    else $error("no-arc result not zero");

  a_closed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_closed_none |-> out_word.last_closed == '0)
    else $error("no closed arc but nonzero");

endmodule

bind vertex_trail_arc_tracker_core vtat_checker u_vtat_checker (.*);

/* sim/vertex_trail_arc_tracker_checker.sv */
module vertex_trail_arc_tracker_checker
  import vtat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [DEG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               words_out
);

  // predicted copy of the vertex state
  logic [DEG_W-1:0]  deg_reg;
  logic [DIST_W-1:0] back_dist [MAX_DEG];
  logic [DIST_W-1:0] fwd_dist [MAX_DEG];
  int                unused_ptr;
  bit                entered [MAX_DEG];
  bit                matched [MAX_DEG];
  int                pair_arc [4];
  bit                pair_ok [2];
  int                closed;
  bit                closed_ok;
  bit                f_grey, f_black, f_even, f_start;
  out_word_t         expected_words [$];

  function automatic int eff_degree();
    return (deg_reg > MAX_DEG) ? MAX_DEG : int'(deg_reg);
  endfunction

  function automatic int step_back(int c, int k, int d);
    return (c % d + d - k % d) % d;
  endfunction

  function automatic int step_fwd(int c, int k, int d);
    return (c % d + k % d) % d;
  endfunction

  function automatic void clear_vertex();
    int d;
    d = eff_degree();
    for (int i = 0; i < MAX_DEG; i++) begin
      back_dist[i] = 1;
      fwd_dist[i]  = 1;
      entered[i]   = 0;
      matched[i]   = 0;
    end
    for (int i = 0; i < 4; i++) pair_arc[i] = 0;
    pair_ok[0] = 0;
    pair_ok[1] = 0;
    unused_ptr = 0;
    closed     = 0;
    closed_ok  = 0;
    f_grey     = 0;
    f_start    = 0;
    f_even     = (d % 2) == 0;
    f_black    = (d == 0);
  endfunction

  // take arc out of the circular list; 0 when it was the only one
  function automatic bit drop_arc(int pos, int d, output int succ);
    int pl, nl, p, n;
    pl = back_dist[pos];
    nl = fwd_dist[pos];
    p  = step_back(pos, pl, d);
    succ = 0;
    if (p == pos) return 0;
    fwd_dist[p] = fwd_dist[p] + DIST_W'(nl);
    n = step_fwd(pos, nl, d);
    back_dist[n] = back_dist[n] + DIST_W'(pl);
    succ = n;
    return 1;
  endfunction

  function automatic int partner(int idx, int d);
    int from, j, sp, o;
    int stk [STACK_DEPTH];
    for (int s = 0; s < 2; s++) begin
      if (pair_ok[s]) begin
        if (pair_arc[2*s] == idx) return pair_arc[2*s+1];
        if (pair_arc[2*s+1] == idx) return pair_arc[2*s];
      end
    end
    if (idx >= d || !matched[idx]) return idx;
    from = closed_ok ? (closed + 1) % d : 0;
    for (int k = 0; k < d && !matched[from]; k++) from = (from + 1) % d;
    j  = from;
    sp = 0;
    for (int k = 0; k < d; k++) begin
      if (matched[j]) begin
        if (entered[j]) begin
          if (sp < STACK_DEPTH) begin
            stk[sp] = j;
            sp++;
          end
        end else if (sp > 0) begin
          sp--;
          o = stk[sp];
          if (idx == o) return j;
          if (idx == j) return o;
        end
      end
      j = (j + 1) % d;
    end
    return idx;
  endfunction

  function automatic void toggle_match(int a, int d);
    if (a < d) matched[a] = !matched[a];
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    int d, a, b, res, n, n2, am, bm, s;
    bit none;
    out_word_t o;
    d = eff_degree();
    a = w.arc_a;
    b = w.arc_b;
    res = 0;
    none = 1;
    case (w.func)
      FN_INIT: clear_vertex();
      FN_LEAVE: begin
        if (!f_black && d != 0) begin
          res = unused_ptr % d;
          none = 0;
          f_grey = 1;
          f_start = 1;
          if (!drop_arc(res, d, n)) begin
            f_black = 1;
            unused_ptr = 0;
          end else begin
            unused_ptr = n;
            f_even = !f_even;
          end
        end
      end
      FN_ENTER: begin
        if (!f_black && d != 0 && a < d) begin
          f_grey = 1;
          entered[a] = 1;
          if (!drop_arc(a, d, n)) begin
            f_black = 1;
            unused_ptr = 0;
          end else begin
            matched[a] = 1;
            matched[n] = 1;
            closed = n;
            closed_ok = 1;
            res = n;
            none = 0;
            if (!drop_arc(n, d, n2)) begin
              f_black = 1;
              unused_ptr = 0;
            end else begin
              unused_ptr = step_back(n2, back_dist[n2], d);
            end
          end
        end
      end
      FN_MARRY: begin
        if (a < d && b < d) begin
          am = partner(a, d);
          bm = partner(b, d);
          s = pair_ok[0] ? 1 : 0;
          toggle_match(am, d);
          toggle_match(a, d);
          toggle_match(bm, d);
          toggle_match(b, d);
          pair_arc[2*s] = a;
          pair_arc[2*s+1] = b;
          pair_ok[s] = 1;
        end
      end
      FN_MATCH: begin
        res = partner(a, d);
        none = 0;
      end
      FN_START: begin
        if (f_start) begin
          for (int i = 0; i < d; i++) begin
            if (partner(i, d) == i && !entered[i]) begin
              res = i;
              none = 0;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    o.result_arc       = none ? '0 : ARC_W'(res);
    o.result_none      = none;
    o.is_black         = f_black;
    o.is_grey          = f_grey;
    o.is_even          = f_even;
    o.has_start        = f_start;
    o.last_closed      = closed_ok ? ARC_W'(closed) : '0;
    o.last_closed_none = !closed_ok;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // observe channels at every rising edge
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      deg_reg = '0;
      clear_vertex();
      expected_words.delete();
      fail_count = 0;
      pending = 0;
      words_out = 0;
    end else begin
      if (out_valid) begin
        words_out++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.result_arc != exp_w.result_arc)
            report_mismatch("result_arc", out_word.result_arc, exp_w.result_arc);
          if (out_word.result_none != exp_w.result_none)
            report_mismatch("result_none", out_word.result_none, exp_w.result_none);
          if (out_word.is_black != exp_w.is_black)
            report_mismatch("is_black", out_word.is_black, exp_w.is_black);
          if (out_word.is_grey != exp_w.is_grey)
            report_mismatch("is_grey", out_word.is_grey, exp_w.is_grey);
          if (out_word.is_even != exp_w.is_even)
            report_mismatch("is_even", out_word.is_even, exp_w.is_even);
          if (out_word.has_start != exp_w.has_start)
            report_mismatch("has_start", out_word.has_start, exp_w.has_start);
          if (out_word.last_closed != exp_w.last_closed)
            report_mismatch("last_closed", out_word.last_closed, exp_w.last_closed);
          if (out_word.last_closed_none != exp_w.last_closed_none)
            report_mismatch("last_closed_none", out_word.last_closed_none,
                            exp_w.last_closed_none);
        end
      end
      if (cfg_we) deg_reg = cfg_wdata;
      if (start && !busy) expected_words.push_back(apply_word(in_word));
      pending = expected_words.size();
    end
  end

endmodule

/* sim/vertex_trail_arc_tracker_core_tb.sv */
module vertex_trail_arc_tracker_core_tb;
  import vtat_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_word_t         in_word;
  logic             out_valid;
  out_word_t        out_word;
  logic             cfg_we;
  logic [DEG_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               words_out;
  int               words_in;
  int               idle_cycles;
  int               burst_left;

  vertex_trail_arc_tracker_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  vertex_trail_arc_tracker_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .words_out(words_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: cycles with no accepted word in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("vertex_trail_arc_tracker_core_tb: FAIL");
        $finish;
      end
    end
  end

  // send one word, with burst/gap pacing before it; start stays high inside a burst
  task automatic send_word(logic [2:0] fn, int a, int b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_word <= '{func: fn, arc_a: 6'(a), arc_b: 6'(b)};
    @(posedge clk);
    while (busy) @(posedge clk);
    words_in++;
  endtask

  // drop start and wait until the last word has left the block
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // change degree only when the block is idle
  task automatic set_degree(int d);
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= DEG_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a plausible trail: leaves and enters with matches mixed in
  task automatic walk_vertex(int d, int len);
    int r;
    int top;
    top = (d > 0) ? d - 1 : 0;
    send_word(FN_INIT, $urandom, $urandom);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 28) send_word(FN_LEAVE, $urandom, $urandom);
      else if (r < 58) send_word(FN_ENTER, $urandom_range(0, top), $urandom);
      else if (r < 68) send_word(FN_MARRY, $urandom_range(0, top), $urandom_range(0, top));
      else if (r < 86) send_word(FN_MATCH, $urandom_range(0, top), $urandom);
      else if (r < 94) send_word(FN_START, $urandom, $urandom);
      else send_word(3'($urandom_range(0, 7)), $urandom, $urandom);
    end
  endtask

  initial begin
    int degs [9] = '{0, 1, 2, 3, 5, 8, 13, 64, 127};
    int d;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    words_in = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degree 0 behavior, unused codes, then a small vertex
    send_word(FN_LEAVE, 0, 0);
    send_word(FN_ENTER, 63, 63);
    send_word(FN_START, 0, 0);
    send_word(3'd6, 63, 0);
    send_word(3'd7, 0, 63);
    set_degree(4);
    send_word(FN_INIT, 0, 0);
    send_word(FN_START, 0, 0);
    send_word(FN_LEAVE, 0, 0);
    send_word(FN_ENTER, 2, 0);
    send_word(FN_ENTER, 2, 0);
    send_word(FN_MATCH, 2, 0);
    send_word(FN_MATCH, 63, 0);
    send_word(FN_MARRY, 0, 3);
    send_word(FN_MARRY, 1, 2);
    send_word(FN_MARRY, 3, 1);
    send_word(FN_MARRY, 63, 0);
    send_word(FN_MATCH, 1, 0);
    send_word(FN_START, 0, 0);
    send_word(FN_LEAVE, 0, 0);
    send_word(FN_LEAVE, 0, 0);
    send_word(FN_ENTER, 0, 0);
    // stale list after a degree change
    set_degree(7);
    send_word(FN_LEAVE, 0, 0);
    send_word(FN_ENTER, 6, 0);

    // random walks; mostly small degrees, a few extremes
    while (words_in < 1900) begin
      d = ($urandom_range(0, 5) == 0) ? degs[$urandom_range(0, 8)] : $urandom_range(1, 12);
      set_degree(d);
      walk_vertex(d, $urandom_range(4, 30));
    end

    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d words over degrees 0 to 127 and extremes; %0d results checked",
             words_in, words_out);
    if (fail_count == 0) begin
      $display("vertex_trail_arc_tracker_core_tb: PASS");
    end else begin
      $display("vertex_trail_arc_tracker_core_tb: FAIL");
    end
    $finish;
  end

endmodule
